/* design/a51kg_pkg.sv */
`default_nettype none
package a51kg_pkg;

    // register lengths
    localparam int unsigned LEN_FIRST  = 19;
    localparam int unsigned LEN_SECOND = 22;
    localparam int unsigned LEN_THIRD  = 23;

    // field widths
    localparam int unsigned OP_W  = 2;
    localparam int unsigned FN_W  = 22;
    localparam int unsigned KEY_W = 64;

    // feedback taps, bit i set when index i is a tap
    localparam logic [LEN_FIRST-1:0]  TAPS_FIRST  = 19'h00027;
    localparam logic [LEN_SECOND-1:0] TAPS_SECOND = 22'h000003;
    localparam logic [LEN_THIRD-1:0]  TAPS_THIRD  = 23'h008007;

    // clocking bit positions
    localparam int unsigned CLK_FIRST  = 10;
    localparam int unsigned CLK_SECOND = 11;
    localparam int unsigned CLK_THIRD  = 12;

    // frame start sequence lengths
    localparam int unsigned KEY_STEPS   = 64;
    localparam int unsigned FRAME_STEPS = 22;
    localparam int unsigned MIX_STEPS   = 100;
    localparam int unsigned CNT_W       = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEED  = 2'd2;

    // what the registers do in one cycle
    typedef enum logic [2:0] {
        STEP_HOLD,
        STEP_LOAD,
        STEP_CLEAR,
        STEP_FORCE,
        STEP_MAJ
    } t_step_mode;

    typedef struct packed {
        t_step_mode mode;
        logic       inj;
    } t_step_ctl;

endpackage
`default_nettype wire

/* design/a51kg_ifs.sv */
`default_nettype none
// input item channel
interface a51kg_in_if;
    logic                                valid;
    logic                                ready;
    logic [a51kg_pkg::OP_W-1:0]          op;
    logic [a51kg_pkg::FN_W-1:0]          frame_id;
    logic [a51kg_pkg::LEN_FIRST-1:0]     seed_first;
    logic [a51kg_pkg::LEN_SECOND-1:0]    seed_second;
    logic [a51kg_pkg::LEN_THIRD-1:0]     seed_third;

    modport source (
        output valid, op, frame_id, seed_first, seed_second, seed_third,
        input  ready
    );
    modport sink (
        input  valid, op, frame_id, seed_first, seed_second, seed_third,
        output ready
    );
endinterface

// result item channel
interface a51kg_out_if;
    logic valid;
    logic ready;
    logic keystream_bit;

    modport source (output valid, keystream_bit, input ready);
    modport sink (input valid, keystream_bit, output ready);
endinterface
`default_nettype wire

/* design/a51kg_lfsr.sv */
`default_nettype none
module a51kg_lfsr (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire a51kg_pkg::t_step_ctl              i_step,
    input  wire logic [a51kg_pkg::LEN_FIRST-1:0]   i_seed_first,
    input  wire logic [a51kg_pkg::LEN_SECOND-1:0]  i_seed_second,
    input  wire logic [a51kg_pkg::LEN_THIRD-1:0]   i_seed_third,
    output logic                                   o_keystream
);

    logic [a51kg_pkg::LEN_FIRST-1:0]  r_first,  n_first;
    logic [a51kg_pkg::LEN_SECOND-1:0] r_second, n_second;
    logic [a51kg_pkg::LEN_THIRD-1:0]  r_third,  n_third;

    logic fb_first, fb_second, fb_third;
    logic ca, cb, cc, maj;
    logic mv_first, mv_second, mv_third;

    // feedback: tap parity plus injected bit (zero outside forced clocking)
    assign fb_first  = (^(r_first  & a51kg_pkg::TAPS_FIRST))  ^ i_step.inj;
    assign fb_second = (^(r_second & a51kg_pkg::TAPS_SECOND)) ^ i_step.inj;
    assign fb_third  = (^(r_third  & a51kg_pkg::TAPS_THIRD))  ^ i_step.inj;

    // majority vote of the clocking bits
    assign ca  = r_first[a51kg_pkg::CLK_FIRST];
    assign cb  = r_second[a51kg_pkg::CLK_SECOND];
    assign cc  = r_third[a51kg_pkg::CLK_THIRD];
    assign maj = (ca & cb) | (ca & cc) | (cb & cc);

    assign o_keystream = r_first[0] ^ r_second[0] ^ r_third[0];

    // which registers move this cycle
    always_comb begin
        mv_first  = 1'b0;
        mv_second = 1'b0;
        mv_third  = 1'b0;
        unique case (i_step.mode)
            a51kg_pkg::STEP_FORCE: begin
                mv_first  = 1'b1;
                mv_second = 1'b1;
                mv_third  = 1'b1;
            end
            a51kg_pkg::STEP_MAJ: begin
                mv_first  = (ca == maj);
                mv_second = (cb == maj);
                mv_third  = (cc == maj);
            end
            default: begin
                mv_first  = 1'b0;
                mv_second = 1'b0;
                mv_third  = 1'b0;
            end
        endcase
    end

    // next register contents
    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_third  = r_third;
        if (i_step.mode == a51kg_pkg::STEP_LOAD) begin
            n_first  = i_seed_first;
            n_second = i_seed_second;
            n_third  = i_seed_third;
        end else if (i_step.mode == a51kg_pkg::STEP_CLEAR) begin
            n_first  = '0;
            n_second = '0;
            n_third  = '0;
        end else begin
            if (mv_first) begin
                n_first = {fb_first, r_first[a51kg_pkg::LEN_FIRST-1:1]};
            end
            if (mv_second) begin
                n_second = {fb_second, r_second[a51kg_pkg::LEN_SECOND-1:1]};
            end
            if (mv_third) begin
                n_third = {fb_third, r_third[a51kg_pkg::LEN_THIRD-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_third  <= '0;
        end else begin
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end

endmodule
`default_nettype wire

/* design/a51kg_ctrl.sv */
`default_nettype none
module a51kg_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [a51kg_pkg::KEY_W-1:0]    i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [a51kg_pkg::OP_W-1:0]     i_op,
    input  wire logic [a51kg_pkg::FN_W-1:0]     i_frame_id,
    output a51kg_pkg::t_step_ctl                o_step,
    output logic                                o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_FRAME,
        ST_MIX
    } t_state;

    localparam logic [a51kg_pkg::CNT_W-1:0] KEY_LAST =
        a51kg_pkg::CNT_W'(a51kg_pkg::KEY_STEPS - 1);
    localparam logic [a51kg_pkg::CNT_W-1:0] FRAME_LAST =
        a51kg_pkg::CNT_W'(a51kg_pkg::FRAME_STEPS - 1);
    localparam logic [a51kg_pkg::CNT_W-1:0] MIX_LAST =
        a51kg_pkg::CNT_W'(a51kg_pkg::MIX_STEPS - 1);

    t_state                          r_state;
    logic [a51kg_pkg::CNT_W-1:0]     r_cnt;
    logic [a51kg_pkg::KEY_W-1:0]     r_session_key;
    logic [a51kg_pkg::KEY_W-1:0]     r_key_sr;
    logic [a51kg_pkg::FN_W-1:0]      r_fn_sr;
    logic                            start;

    assign start  = i_accept && (i_op == a51kg_pkg::OP_START);
    assign o_busy = (r_state != ST_IDLE);

    // register command for this cycle
    always_comb begin
        o_step = '{mode: a51kg_pkg::STEP_HOLD, inj: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    unique case (i_op)
                        a51kg_pkg::OP_START: o_step.mode = a51kg_pkg::STEP_CLEAR;
                        a51kg_pkg::OP_NEXT:  o_step.mode = a51kg_pkg::STEP_MAJ;
                        a51kg_pkg::OP_SEED:  o_step.mode = a51kg_pkg::STEP_LOAD;
                        default:             o_step.mode = a51kg_pkg::STEP_HOLD;
                    endcase
                end
            end
            ST_KEY: begin
                o_step.mode = a51kg_pkg::STEP_FORCE;
                o_step.inj  = r_key_sr[0];
            end
            ST_FRAME: begin
                o_step.mode = a51kg_pkg::STEP_FORCE;
                o_step.inj  = r_fn_sr[0];
            end
            ST_MIX: begin
                o_step.mode = a51kg_pkg::STEP_MAJ;
            end
            default: begin
                o_step.mode = a51kg_pkg::STEP_HOLD;
            end
        endcase
    end

    // frame start sequencer and key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_session_key <= '0;
        end else begin
            if (i_cfg_we) begin
                r_session_key <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (start) begin
                        r_state <= ST_KEY;
                    end
                end
                ST_KEY: begin
                    if (r_cnt == KEY_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_FRAME;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FRAME: begin
                    if (r_cnt == FRAME_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_MIX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MIX: begin
                    if (r_cnt == MIX_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_cnt   <= '0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // key and frame number shift out one bit per cycle, bit 0 first
    always_ff @(posedge i_clk) begin
        if (start && !o_busy) begin
            r_key_sr <= r_session_key;
            r_fn_sr  <= i_frame_id;
        end else begin
            if (r_state == ST_KEY) begin
                r_key_sr <= {1'b0, r_key_sr[a51kg_pkg::KEY_W-1:1]};
            end
            if (r_state == ST_FRAME) begin
                r_fn_sr <= {1'b0, r_fn_sr[a51kg_pkg::FN_W-1:1]};
            end
        end
    end

endmodule
`default_nettype wire

/* design/a51_keystream_generator_top.sv */
// Keystream item (op 1): result in the output register in the cycle after acceptance,
//   one item per cycle while the result side keeps up.
// Seed load (op 2) and ignored codes leave the input open for the next item.
// Frame start (op 0) keeps the input closed after acceptance while 64 key bits and 22
//   frame bits are shifted in one per cycle, then during 100 majority steps.
// Synchronous active-low reset clears the three registers, the session key and the output.
`default_nettype none
module a51_keystream_generator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [a51kg_pkg::KEY_W-1:0]   i_cfg_data,
    a51kg_in_if.sink                           i_in,
    a51kg_out_if.source                        o_out
);

    a51kg_pkg::t_step_ctl step;
    logic                 busy;
    logic                 accept;
    logic                 ks_bit;
    logic                 r_out_valid;
    logic                 r_out_bit;

    // take a new item when the sequencer is free and the output slot can drain
    assign i_in.ready = !busy && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    a51kg_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_op           (i_in.op),
        .i_frame_id     (i_in.frame_id),
        .o_step         (step),
        .o_busy         (busy)
    );

    a51kg_lfsr u_lfsr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_seed_first  (i_in.seed_first),
        .i_seed_second (i_in.seed_second),
        .i_seed_third  (i_in.seed_third),
        .o_keystream   (ks_bit)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && (i_in.op == a51kg_pkg::OP_NEXT)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_bit <= 1'b0;
        end else if (accept && (i_in.op == a51kg_pkg::OP_NEXT)) begin
            r_out_bit <= ks_bit;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.keystream_bit = r_out_bit;

endmodule
`default_nettype wire

/* sim/a51_keystream_generator_top_tb.sv */
`default_nettype none
module a51_keystream_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // op code the block ignores
    localparam logic [a51kg_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

    localparam int unsigned SETTLE_CYCLES = 200;   // long enough to cover a frame start
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned PHASE_ITEMS   = 170;

    typedef struct packed {
        logic [a51kg_pkg::OP_W-1:0]       op;
        logic [a51kg_pkg::FN_W-1:0]       fn;
        logic [a51kg_pkg::LEN_FIRST-1:0]  seed_first;
        logic [a51kg_pkg::LEN_SECOND-1:0] seed_second;
        logic [a51kg_pkg::LEN_THIRD-1:0]  seed_third;
    } t_ks_item;

    typedef struct {
        t_ks_item it;
        bit       typed;
        logic     ks;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [a51kg_pkg::KEY_W-1:0] i_cfg_data;

    a51kg_in_if  in_ch();
    a51kg_out_if out_ch();

    a51_keystream_generator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state
    logic [a51kg_pkg::LEN_FIRST-1:0]  lfsr_a;
    logic [a51kg_pkg::LEN_SECOND-1:0] lfsr_b;
    logic [a51kg_pkg::LEN_THIRD-1:0]  lfsr_c;
    logic [a51kg_pkg::KEY_W-1:0]      sess_key;

    logic      ks_expected[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        src_gaps;
    bit        sink_gaps;
    bit        hold_req = 1'b0;
    t_stim_row directed_tab[$];

    // one plain shift with feedback into the top index
    function automatic logic [a51kg_pkg::LEN_THIRD-1:0] lfsr_shift(
            input logic [a51kg_pkg::LEN_THIRD-1:0] r,
            input logic [a51kg_pkg::LEN_THIRD-1:0] taps,
            input int unsigned len,
            input logic inj);
        logic fb;
        fb = (^(r & taps)) ^ inj;
        r = r >> 1;
        r[len-1] = fb;
        return r;
    endfunction

    function automatic void shift_all(input logic inj);
        lfsr_a = a51kg_pkg::LEN_FIRST'(lfsr_shift(a51kg_pkg::LEN_THIRD'(lfsr_a),
                     a51kg_pkg::LEN_THIRD'(a51kg_pkg::TAPS_FIRST), a51kg_pkg::LEN_FIRST, inj));
        lfsr_b = a51kg_pkg::LEN_SECOND'(lfsr_shift(a51kg_pkg::LEN_THIRD'(lfsr_b),
                     a51kg_pkg::LEN_THIRD'(a51kg_pkg::TAPS_SECOND), a51kg_pkg::LEN_SECOND, inj));
        lfsr_c = lfsr_shift(lfsr_c, a51kg_pkg::TAPS_THIRD, a51kg_pkg::LEN_THIRD, inj);
    endfunction

    // registers whose clocking bit agrees with the majority move
    function automatic void majority_advance();
        logic a, b, c, maj;
        a = lfsr_a[a51kg_pkg::CLK_FIRST];
        b = lfsr_b[a51kg_pkg::CLK_SECOND];
        c = lfsr_c[a51kg_pkg::CLK_THIRD];
        maj = (a & b) | (a & c) | (b & c);
        if (a == maj)
            lfsr_a = a51kg_pkg::LEN_FIRST'(lfsr_shift(a51kg_pkg::LEN_THIRD'(lfsr_a),
                         a51kg_pkg::LEN_THIRD'(a51kg_pkg::TAPS_FIRST),
                         a51kg_pkg::LEN_FIRST, 1'b0));
        if (b == maj)
            lfsr_b = a51kg_pkg::LEN_SECOND'(lfsr_shift(a51kg_pkg::LEN_THIRD'(lfsr_b),
                         a51kg_pkg::LEN_THIRD'(a51kg_pkg::TAPS_SECOND),
                         a51kg_pkg::LEN_SECOND, 1'b0));
        if (c == maj)
            lfsr_c = lfsr_shift(lfsr_c, a51kg_pkg::TAPS_THIRD, a51kg_pkg::LEN_THIRD, 1'b0);
    endfunction

    // returns 1 when the item yields a keystream bit
    function automatic bit predict_keystream(input t_ks_item it, output logic ks);
        ks = 1'b0;
        case (it.op)
            a51kg_pkg::OP_START: begin
                lfsr_a = '0;
                lfsr_b = '0;
                lfsr_c = '0;
                for (int k = 0; k < a51kg_pkg::KEY_STEPS; k++)
                    shift_all(sess_key[k]);
                for (int k = 0; k < a51kg_pkg::FRAME_STEPS; k++)
                    shift_all(it.fn[k]);
                for (int k = 0; k < a51kg_pkg::MIX_STEPS; k++)
                    majority_advance();
                return 1'b0;
            end
            a51kg_pkg::OP_NEXT: begin
                ks = lfsr_a[0] ^ lfsr_b[0] ^ lfsr_c[0];
                majority_advance();
                return 1'b1;
            end
            a51kg_pkg::OP_SEED: begin
                lfsr_a = it.seed_first;
                lfsr_b = it.seed_second;
                lfsr_c = it.seed_third;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_stim_row row(input logic [a51kg_pkg::OP_W-1:0] op,
                                      input logic [a51kg_pkg::FN_W-1:0] fn,
                                      input logic [a51kg_pkg::LEN_FIRST-1:0] s1,
                                      input logic [a51kg_pkg::LEN_SECOND-1:0] s2,
                                      input logic [a51kg_pkg::LEN_THIRD-1:0] s3,
                                      input bit typed, input logic ks);
        t_stim_row r;
        r.it = '{op: op, fn: fn, seed_first: s1, seed_second: s2, seed_third: s3};
        r.typed = typed;
        r.ks = ks;
        return r;
    endfunction

    function automatic t_ks_item rand_item(input logic [a51kg_pkg::OP_W-1:0] op);
        t_ks_item it;
        it.op = op;
        it.fn = a51kg_pkg::FN_W'($urandom);
        it.seed_first = a51kg_pkg::LEN_FIRST'($urandom);
        it.seed_second = a51kg_pkg::LEN_SECOND'($urandom);
        it.seed_third = a51kg_pkg::LEN_THIRD'($urandom);
        return it;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[a51_keystream_generator_top] ERROR");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (ks_expected.size() == 0) begin
                $error("keystream_bit: no item expected, actual %0b", out_ch.keystream_bit);
                mismatches++;
            end else begin
                logic exp_ks;
                exp_ks = ks_expected.pop_front();
                if (out_ch.keystream_bit !== exp_ks) begin
                    $error("keystream_bit: expected %0b, actual %0b", exp_ks,
                           out_ch.keystream_bit);
                    mismatches++;
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // offer one item, called and returning at a falling edge
    task automatic send_item(input t_ks_item it, input bit typed = 1'b0,
                             input logic typed_ks = 1'b0);
        logic ks;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.frame_id    <= it.fn;
        in_ch.seed_first  <= it.seed_first;
        in_ch.seed_second <= it.seed_second;
        in_ch.seed_third  <= it.seed_third;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (predict_keystream(it, ks))
            ks_expected.push_back(typed ? typed_ks : ks);
        @(negedge i_clk);
    endtask

    // key update only once the block has gone quiet
    task automatic write_key(input logic [a51kg_pkg::KEY_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (ks_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sess_key = v;
    endtask

    // mostly frame starts or seed loads followed by keystream runs
    task automatic run_traffic(input int n_items);
        int done;
        int r;
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_item(rand_item(a51kg_pkg::OP_START));
                done++;
                repeat ($urandom_range(3, 25)) begin
                    send_item(rand_item(a51kg_pkg::OP_NEXT));
                    done++;
                end
            end else if (r < 30) begin
                send_item(rand_item(a51kg_pkg::OP_SEED));
                done++;
                repeat ($urandom_range(2, 20)) begin
                    send_item(rand_item(a51kg_pkg::OP_NEXT));
                    done++;
                end
            end else if (r < 35) begin
                // lone frame start; the next item waits until it has finished
                send_item(rand_item(a51kg_pkg::OP_START));
                done++;
            end else if (r < 41) begin
                send_item(rand_item(OP_UNDEF));
            end else begin
                send_item(rand_item(a51kg_pkg::OP_NEXT));
                done++;
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= a51kg_pkg::OP_START;
        in_ch.frame_id    <= '0;
        in_ch.seed_first  <= '0;
        in_ch.seed_second <= '0;
        in_ch.seed_third  <= '0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        lfsr_a     = '0;
        lfsr_b     = '0;
        lfsr_c     = '0;
        sess_key   = '0;

        // directed rows; typed values hold where they are obvious
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b0)); // after reset
        directed_tab.push_back(row(OP_UNDEF, '1, '1, '1, '1, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_SEED, '0, '1, '1, '1, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b1));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '1, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_SEED, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_SEED, '0, 19'd1, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b1));
        directed_tab.push_back(row(a51kg_pkg::OP_SEED, '0, '0, '1, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b1));
        directed_tab.push_back(row(a51kg_pkg::OP_SEED, '0, '0, '0, '1, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b1));
        directed_tab.push_back(row(a51kg_pkg::OP_SEED, '0, 19'h55555, 22'h2AAAAA, 23'h555555,
                                   1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b1, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_START, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_START, '1, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_START, 22'h155555, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(OP_UNDEF, '0, '0, '0, '0, 1'b0, 1'b0));
        directed_tab.push_back(row(a51kg_pkg::OP_NEXT, '0, '0, '0, '0, 1'b0, 1'b0));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all-ones key for the directed part
        write_key('1);
        foreach (directed_tab[i])
            send_item(directed_tab[i].it, directed_tab[i].typed, directed_tab[i].ks);

        write_key('0);
        run_traffic(PHASE_ITEMS);

        // long receiver hold-off while keystream items keep coming
        write_key({$urandom, $urandom});
        send_item(rand_item(a51kg_pkg::OP_START));
        hold_req = 1'b1;
        repeat (60) send_item(rand_item(a51kg_pkg::OP_NEXT));
        run_traffic(PHASE_ITEMS);

        write_key(64'h8000_0000_0000_0001);
        run_traffic(PHASE_ITEMS);

        // last stretch at full rate
        write_key({$urandom, $urandom});
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_traffic(PHASE_ITEMS);

        in_ch.valid <= 1'b0;
        while (ks_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("[a51_keystream_generator_top] OK");
        else
            $display("[a51_keystream_generator_top] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
